// File: sv/uas_pkg.sv
// uas_pkg: shared constants, register codes and stage tag type for the
// upwind advection stencil. No dependencies.
package uas_pkg;

  localparam int DEF_MAX_GRID    = 1024;
  localparam int DEF_SAMPLE_BITS = 18;

  localparam int FRAC_BITS      = 15;
  localparam int COEF_BITS      = 16;
  localparam int GRID_CFG_BITS  = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [GRID_CFG_BITS-1:0] GRID_RESET = 11'd1000;
  localparam logic [COEF_BITS-1:0]     COEF_RESET = 16'd16384;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_COEF_X    = 2'd1,
    CFG_COEF_Y    = 2'd2
  } cfg_reg_t;

  // per-sample control that travels with the data down the pipeline
  typedef struct packed {
    logic interior;
    logic eof;
  } uas_tag_t;

endpackage

// File: sv/uas_line_buffer.sv
// uas_line_buffer: single-port line buffer holding the previous grid row,
// read-before-write with registered read data. Depends on uas_pkg.
module uas_line_buffer #(
  parameter int DEPTH = uas_pkg::DEF_MAX_GRID,
  parameter int WIDTH = uas_pkg::DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // the read returns the value from one row earlier before it is replaced
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata     <= mem[addr];
    end
  end

endmodule

// File: sv/uas_update.sv
// uas_update: two-stage update datapath (products, then round, subtract and
// saturate) with the output register. Depends on uas_pkg.
module uas_update #(
  parameter int SAMPLE_BITS = uas_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s1_valid,
  input  uas_pkg::uas_tag_t                   s1_tag,
  input  logic signed [SAMPLE_BITS-1:0]       s1_u,
  input  logic signed [SAMPLE_BITS-1:0]       s1_up,
  input  logic signed [SAMPLE_BITS-1:0]       s1_left,
  input  logic [uas_pkg::COEF_BITS-1:0]       coef_x,
  input  logic [uas_pkg::COEF_BITS-1:0]       coef_y,
  output logic                                s1_take,
  output logic                                out_valid,
  output logic [SAMPLE_BITS-1:0]              out_sample,
  output logic                                out_last,
  input  logic                                out_ready
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int PW = DW + uas_pkg::COEF_BITS + 1;
  localparam int RW = PW + 1;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic signed [RW-1:0] HALF   = RW'(64'sd1 <<< (uas_pkg::FRAC_BITS - 1));

  logic                          v2_r, v3_r;
  logic                          en2, en3;
  logic signed [PW-1:0]          prod_x_r, prod_y_r;
  logic signed [SAMPLE_BITS-1:0] u2_r;
  uas_pkg::uas_tag_t             tag2_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_last_r;

  logic signed [DW-1:0]          dx, dy;
  logic signed [uas_pkg::COEF_BITS:0] cx, cy;
  logic signed [RW-1:0]          sum, quo, res, sat;

  assign en3     = !v3_r || out_ready;
  assign en2     = !v2_r || en3;
  assign s1_take = en2;

  assign dx = DW'(s1_u) - DW'(s1_up);
  assign dy = DW'(s1_u) - DW'(s1_left);
  assign cx = {1'b0, coef_x};
  assign cy = {1'b0, coef_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      prod_x_r <= PW'(cx * dx);
      prod_y_r <= PW'(cy * dy);
      u2_r     <= s1_u;
      tag2_r   <= s1_tag;
    end
  end

  // round half up, then floor shift back to the sample grid
  always_comb begin
    sum = RW'(prod_x_r) + RW'(prod_y_r) + HALF;
    quo = sum >>> uas_pkg::FRAC_BITS;
    res = RW'(u2_r) - quo;
    if (!tag2_r.interior) begin
      sat = RW'(u2_r);
    end else if (res > SAT_HI) begin
      sat = SAT_HI;
    end else if (res < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      out_sample_r <= sat[SAMPLE_BITS-1:0];
      out_last_r   <= tag2_r.eof;
    end
  end

  assign out_valid  = v3_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

// File: sv/upwind_advection_stencil.sv
// Upwind advection stencil: one timestep of a 2D first-order upwind update on
// a square grid streamed in raster order, one result per input sample. Takes
// one sample per clock cycle sustained while out_tready is high; a result
// passes three registered stages after its sample is taken (line buffer read,
// products, round and saturate). While results wait downstream the pipeline
// keeps accepting until its three stages hold data, then stalls the input.
// The line buffer is one single-port memory of MAX_GRID entries, read and
// written once per sample; it needs no clearing after reset. Samples in row 0
// and column 0 pass through unchanged; tlast marks the last sample of the grid.
// Depends on uas_pkg, uas_line_buffer and uas_update.
module upwind_advection_stencil #(
  parameter int MAX_GRID    = uas_pkg::DEF_MAX_GRID,
  parameter int SAMPLE_BITS = uas_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [uas_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [uas_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // in_tdata: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // out_tdata: new_sample
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,
  output logic                                     out_tlast
);

  localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W = $clog2(MAX_GRID);
  localparam int CW    = (uas_pkg::GRID_CFG_BITS > IDX_W + 1) ?
                         uas_pkg::GRID_CFG_BITS : IDX_W + 1;

  logic [uas_pkg::GRID_CFG_BITS-1:0] grid_size_r;
  logic [uas_pkg::COEF_BITS-1:0]     coef_x_r, coef_y_r;

  logic [IDX_W-1:0]              col_r, row_r, last_idx;
  logic [CW-1:0]                 grid_ext, n_eff;
  logic                          last_col, last_row, accept, s1_take;
  logic signed [SAMPLE_BITS-1:0] sample, left_r, u1_r, left1_r, up1;
  logic                          v1_r;
  uas_pkg::uas_tag_t             tag1_r;
  logic [SAMPLE_BITS-1:0]        out_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= uas_pkg::GRID_RESET;
      coef_x_r    <= uas_pkg::COEF_RESET;
      coef_y_r    <= uas_pkg::COEF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uas_pkg::CFG_GRID_SIZE: grid_size_r <= cfg_wdata[uas_pkg::GRID_CFG_BITS-1:0];
        uas_pkg::CFG_COEF_X:    coef_x_r    <= cfg_wdata[uas_pkg::COEF_BITS-1:0];
        uas_pkg::CFG_COEF_Y:    coef_y_r    <= cfg_wdata[uas_pkg::COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range grid sizes clamp to the supported span
  always_comb begin
    grid_ext = CW'(grid_size_r);
    if (grid_ext < CW'(2)) begin
      n_eff = CW'(2);
    end else if (grid_ext > CW'(MAX_GRID)) begin
      n_eff = CW'(MAX_GRID);
    end else begin
      n_eff = grid_ext;
    end
    last_idx = IDX_W'(n_eff - CW'(1));
  end

  assign last_col  = col_r >= last_idx;
  assign last_row  = row_r >= last_idx;
  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = !v1_r || s1_take;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      v1_r   <= 1'b0;
    end else begin
      if (in_tready) begin
        v1_r <= in_tvalid;
      end
      if (accept) begin
        left_r <= sample;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + IDX_W'(1);
        end else begin
          col_r <= col_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u1_r            <= sample;
      left1_r         <= left_r;
      tag1_r.interior <= (row_r != '0) && (col_r != '0);
      tag1_r.eof      <= last_col && last_row;
    end
  end

  uas_line_buffer #(
    .DEPTH (MAX_GRID),
    .WIDTH (SAMPLE_BITS)
  ) u_line_buffer (
    .clk   (clk),
    .en    (accept),
    .addr  (col_r),
    .wdata (sample),
    .rdata (up1)
  );

  uas_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (v1_r),
    .s1_tag     (tag1_r),
    .s1_u       (u1_r),
    .s1_up      (up1),
    .s1_left    (left1_r),
    .coef_x     (coef_x_r),
    .coef_y     (coef_y_r),
    .s1_take    (s1_take),
    .out_valid  (out_tvalid),
    .out_sample (out_sample),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

  assign out_tdata = TDW'(out_sample);

endmodule
